@@ design/fxnlms_pkg.sv @@
// fxnlms_pkg: sizes, fixed path coefficient tables and widths for the
// filtered-x nlms noise canceller core
// no dependencies
package fxnlms_pkg;

	// filter lengths
	localparam int ADAPT_TAPS     = 1024;
	localparam int PRIMARY_TAPS   = 18;
	localparam int SECONDARY_TAPS = 12;
	localparam int REC_TAPS       = (PRIMARY_TAPS > SECONDARY_TAPS) ? PRIMARY_TAPS
	                                                                 : SECONDARY_TAPS;

	// index and counter widths
	localparam int ADDR_W = $clog2(ADAPT_TAPS);
	localparam int CNT_W  = $clog2(2 * ADAPT_TAPS + 2);
	localparam int REC_IW = (REC_TAPS > 1) ? $clog2(REC_TAPS) : 1;
	localparam int SEC_IW = (SECONDARY_TAPS > 1) ? $clog2(SECONDARY_TAPS) : 1;

	// coefficient tables, q1.15
	localparam int PRI_TABLE_LEN = 18;
	localparam int SEC_TABLE_LEN = 12;
	localparam int PRI_TW        = $clog2(PRI_TABLE_LEN);
	localparam int SEC_TW        = $clog2(SEC_TABLE_LEN);

	localparam logic signed [15:0] PRI_COEF [PRI_TABLE_LEN] = '{
		16'sd2110, -16'sd826, 16'sd1362, -16'sd1417, 16'sd2185, -16'sd2608,
		16'sd4164, -16'sd6703, 16'sd20983, 16'sd20983, -16'sd6703, 16'sd4164,
		-16'sd2608, 16'sd2185, -16'sd1417, 16'sd1362, -16'sd826, 16'sd2110
	};
	localparam logic signed [15:0] SEC_COEF [SEC_TABLE_LEN] = '{
		-16'sd3365, 16'sd1910, -16'sd2647, 16'sd3930, -16'sd6805, 16'sd20811,
		16'sd20811, -16'sd6805, 16'sd3930, -16'sd2647, 16'sd1910, -16'sd3365
	};

	// register reset
	localparam logic [15:0] STEP_RESET = 16'd6554;

	// datapath widths
	localparam int ACC_W     = 64;
	localparam int MA_W      = 33;
	localparam int MB_W      = 25;
	localparam int PROD_W    = MA_W + MB_W;
	localparam int D_W       = 38;
	localparam int Y1_W      = 54;
	localparam int EMAG_W    = 31;
	localparam int K_W       = EMAG_W + 24;
	localparam int K_LO_W    = 23;
	localparam int K_CAP_BIT = 45;
	localparam int K_HI_W    = K_CAP_BIT - K_LO_W;
	localparam int LO_W      = K_LO_W + 24;
	localparam int HI_W      = K_HI_W + 24;
	localparam int UPROD_W   = HI_W + K_LO_W + 1;
	localparam int DVS_W     = 64;
	localparam int DELTA_W   = 41;

	function automatic logic signed [15:0] pri_coef(input logic [CNT_W-1:0] idx);
		logic signed [15:0] c;
		c = '0;
		if (idx < CNT_W'(PRI_TABLE_LEN)) c = PRI_COEF[idx[PRI_TW-1:0]];
		return c;
	endfunction

	function automatic logic signed [15:0] sec_coef(input logic [CNT_W-1:0] idx);
		logic signed [15:0] c;
		c = '0;
		if (idx < CNT_W'(SEC_TABLE_LEN)) c = SEC_COEF[idx[SEC_TW-1:0]];
		return c;
	endfunction

endpackage

@@ design/fxnlms_ram.sv @@
// fxnlms_ram: generic single write, single read ram with registered read
// no dependencies
module fxnlms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

@@ design/fxnlms_noise_canceller_core.sv @@
// fxnlms_noise_canceller_core: filtered-x nlms active noise control loop
// depends on fxnlms_pkg and fxnlms_ram
//
// usage:
//   input channel (in_valid, in_stall, reference_sample) takes one signed
//   16-bit reference request; output channel (out_valid, out_stall,
//   error_sample) returns one saturated 16-bit error per request
//   apb port: step_size at byte address 0 (low 16 bits of the word)
//   per request the one shared 33x25 multiplier walks: primary taps, the
//   adaptive taps, the secondary path twice, two power terms, |e|*mu, then
//   two partial products per weight for the update; a radix-2 divider forms
//   the normalized gain in between
//   in_stall is high from accept until the result is written out, so only one
//   request is in flight at a time
//   reset: all history is cleared; the three tap memories are cleared by a
//   sweep over all ADAPT_TAPS addresses after reset, with in_stall high
//   a result waits in the output register while out_stall is high; the
//   next request is taken meanwhile, and only its final write-out waits
module fxnlms_noise_canceller_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] reference_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] error_sample
);
	import fxnlms_pkg::*;

	// sequencer states
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_PRI   = 4'd2;
	localparam logic [3:0] S_Y     = 4'd3;
	localparam logic [3:0] S_YFIN  = 4'd4;
	localparam logic [3:0] S_SEC   = 4'd5;
	localparam logic [3:0] S_XF    = 4'd6;
	localparam logic [3:0] S_XFIN  = 4'd7;
	localparam logic [3:0] S_POW   = 4'd8;
	localparam logic [3:0] S_ERR   = 4'd9;
	localparam logic [3:0] S_EMAG  = 4'd10;
	localparam logic [3:0] S_DIV   = 4'd11;
	localparam logic [3:0] S_UPD   = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	localparam logic [CNT_W-1:0] UPD_LAST = CNT_W'(2 * ADAPT_TAPS + 1);

	// control and state
	logic [3:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [ADDR_W-1:0]       head_q;
	logic [15:0]             step_q;
	logic signed [15:0]      recent_q [REC_TAPS];
	logic signed [31:0]      ah_q [SECONDARY_TAPS];
	logic [63:0]             pow_q;
	logic signed [23:0]      oldf_q;
	logic signed [23:0]      f_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [D_W-1:0]   d_q;
	logic signed [Y1_W-1:0]  y1_q;
	logic signed [15:0]      e_q;
	logic [K_W-1:0]          num_q;
	logic [DVS_W-1:0]        rem_q;
	logic [DVS_W-1:0]        dvs_q;
	logic                    out_valid_q;
	logic signed [15:0]      out_data_q;

	// multiplier pipeline
	logic signed [MA_W-1:0]   opa_s1;
	logic signed [MB_W-1:0]   opb_s1;
	logic                     v_s1;
	logic                     neg_s1;
	logic                     ram_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2;
	logic                     neg_s2;

	// weight update pipeline
	logic signed [23:0] xi_q;
	logic signed [31:0] w_q;
	logic [LO_W-1:0]    lo_q;

	// memories
	logic              ref_we, f_we, w_we;
	logic [ADDR_W-1:0] ref_waddr, f_waddr, w_waddr;
	logic [ADDR_W-1:0] ref_raddr, f_raddr, w_raddr;
	logic [15:0]       ref_wdata, ref_rd;
	logic [23:0]       f_wdata, f_rd;
	logic [31:0]       w_wdata, w_rd;

	// apb: single register, always ready
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {16'd0, step_q} : 32'd0;

	// handshake
	logic accept;
	assign in_stall     = (state_q != S_IDLE);
	assign accept       = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign error_sample = out_data_q;

	// mac sequencing: issue while cnt < len, finish at cnt == len + 1 as the last product reaches the accumulator
	logic             mac_state;
	logic [CNT_W-1:0] mac_len;
	logic             issue;
	logic             mac_last;

	always_comb begin
		mac_state = 1'b1;
		mac_len   = '0;
		unique case (state_q)
			S_PRI:   mac_len = CNT_W'(PRIMARY_TAPS);
			S_Y:     mac_len = CNT_W'(ADAPT_TAPS);
			S_SEC:   mac_len = CNT_W'(SECONDARY_TAPS);
			S_XF:    mac_len = CNT_W'(SECONDARY_TAPS);
			S_POW:   mac_len = CNT_W'(2);
			S_EMAG:  mac_len = CNT_W'(1);
			default: mac_state = 1'b0;
		endcase
	end

	assign issue    = mac_state && (cnt_q < mac_len);
	assign mac_last = mac_state && (cnt_q == mac_len + CNT_W'(1));

	// circular history addressing, index 0 is the newest sample at head_q
	logic [ADDR_W-1:0] head_dec;
	logic [ADDR_W-1:0] ofs_idx;
	logic [ADDR_W:0]   hsum;
	logic [ADDR_W-1:0] hist_addr;
	logic [CNT_W-1:0]  cnt_m3;

	assign head_dec  = (head_q == '0) ? ADDR_W'(ADAPT_TAPS - 1) : head_q - ADDR_W'(1);
	assign ofs_idx   = (state_q == S_UPD) ? cnt_q[ADDR_W:1] : cnt_q[ADDR_W-1:0];
	assign hsum      = {1'b0, head_q} + {1'b0, ofs_idx};
	assign hist_addr = (hsum >= (ADDR_W+1)'(ADAPT_TAPS))
	                 ? ADDR_W'(hsum - (ADDR_W+1)'(ADAPT_TAPS)) : hsum[ADDR_W-1:0];
	assign cnt_m3    = cnt_q - CNT_W'(3);

	// fixed path coefficients for the current tap
	logic signed [15:0] pri_c;
	logic signed [15:0] sec_c;
	assign pri_c = pri_coef(cnt_q);
	assign sec_c = sec_coef(cnt_q);

	// rounding and saturation of the filter outputs
	logic signed [ACC_W-1:0] an_t, f_t, e_diff, e_t;
	logic signed [31:0]      an_new;
	logic signed [23:0]      f_new;
	logic signed [15:0]      e_new;

	always_comb begin
		// anti-noise q24.8: round half up, saturate to 32 bits
		an_t = (acc_q + ACC_W'(64'sd2097152)) >>> 22;
		if (an_t > ACC_W'(64'sd2147483647))       an_new = 32'sh7fffffff;
		else if (an_t < -ACC_W'(64'sd2147483648)) an_new = 32'sh80000000;
		else                                      an_new = an_t[31:0];
		// filtered reference q18.6: round half up, saturate to 24 bits
		f_t = (acc_q + ACC_W'(64'sd256)) >>> 9;
		if (f_t > ACC_W'(64'sd8388607))       f_new = 24'sh7fffff;
		else if (f_t < -ACC_W'(64'sd8388608)) f_new = 24'sh800000;
		else                                  f_new = f_t[23:0];
		// error: truncate toward zero, saturate to 16 bits
		e_diff = ({{(ACC_W-D_W){d_q[D_W-1]}}, d_q} <<< 8)
		       - {{(ACC_W-Y1_W){y1_q[Y1_W-1]}}, y1_q};
		e_t = (e_diff + (e_diff[ACC_W-1] ? ACC_W'(64'sd8388607) : ACC_W'(0))) >>> 23;
		if (e_t > ACC_W'(64'sd32767))       e_new = 16'sh7fff;
		else if (e_t < -ACC_W'(64'sd32768)) e_new = 16'sh8000;
		else                                e_new = e_t[15:0];
	end

	// magnitudes
	logic [16:0] e_abs;
	logic [23:0] frd_abs, xi_abs;
	assign e_abs   = e_q[15] ? (17'd0 - {e_q[15], e_q}) : {1'b0, e_q};
	assign frd_abs = f_rd[23] ? (24'd0 - f_rd) : f_rd;
	assign xi_abs  = xi_q[23] ? (24'd0 - xi_q) : xi_q;

	// shared multiplier operand select
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;

	always_comb begin
		if (state_q == S_UPD) begin
			if (cnt_q[0]) begin
				// low partial product of gain times |x1|
				mul_a = {{(MA_W-K_LO_W){1'b0}}, num_q[K_LO_W-1:0]};
				mul_b = {{(MB_W-24){1'b0}}, frd_abs};
			end else begin
				mul_a = {{(MA_W-K_HI_W){1'b0}}, num_q[K_CAP_BIT-1:K_LO_W]};
				mul_b = {{(MB_W-24){1'b0}}, xi_abs};
			end
		end else if (ram_s1) begin
			mul_a = {w_rd[31], w_rd};
			mul_b = {{(MB_W-16){ref_rd[15]}}, ref_rd};
		end else begin
			mul_a = opa_s1;
			mul_b = opb_s1;
		end
	end

	// weight update combine: delta = min(k*|x1| >> 4, 2^40), signed, saturated add
	logic [UPROD_W-1:0]  uprod;
	logic [UPROD_W-5:0]  mraw;
	logic                kbig;
	logic                mcap;
	logic [DELTA_W-1:0]  mdelta;
	logic                uneg;
	logic signed [42:0]  wsum;
	logic signed [31:0]  w_new;
	logic                upd_wr;

	assign uprod  = (UPROD_W'(prod_s2[HI_W-1:0]) << K_LO_W) + UPROD_W'(lo_q);
	assign mraw   = uprod[UPROD_W-1:4];
	assign kbig   = |num_q[K_W-1:K_CAP_BIT];
	assign mcap   = (kbig && (xi_q != '0))
	              || (mraw > (UPROD_W-4)'({1'b1, {(DELTA_W-1){1'b0}}}));
	assign mdelta = mcap ? {1'b1, {(DELTA_W-1){1'b0}}} : mraw[DELTA_W-1:0];
	assign uneg   = e_q[15] ^ xi_q[23];
	assign wsum   = uneg ? (43'(w_q) - $signed({2'b00, mdelta}))
	                     : (43'(w_q) + $signed({2'b00, mdelta}));
	assign w_new  = (wsum > 43'sd2147483647) ? 32'sh7fffffff
	              : (wsum < -43'sd2147483648) ? 32'sh80000000 : wsum[31:0];
	assign upd_wr = (state_q == S_UPD) && cnt_q[0] && (cnt_q >= CNT_W'(3));

	// divider step
	logic [DVS_W-1:0] rem_sh;
	logic             rem_ge;
	assign rem_sh = {rem_q[DVS_W-2:0], num_q[K_W-1]};
	assign rem_ge = (rem_sh >= dvs_q);

	// memory hookup
	always_comb begin
		ref_we    = (state_q == S_CLEAR) || accept;
		ref_waddr = (state_q == S_CLEAR) ? cnt_q[ADDR_W-1:0] : head_dec;
		ref_wdata = (state_q == S_CLEAR) ? 16'd0 : reference_sample;
		ref_raddr = hist_addr;

		f_we    = (state_q == S_CLEAR) || (state_q == S_XFIN);
		f_waddr = (state_q == S_CLEAR) ? cnt_q[ADDR_W-1:0] : head_q;
		f_wdata = (state_q == S_CLEAR) ? 24'd0 : f_new;
		f_raddr = (state_q == S_IDLE) ? head_dec : hist_addr;

		w_we    = (state_q == S_CLEAR) || upd_wr;
		w_waddr = (state_q == S_CLEAR) ? cnt_q[ADDR_W-1:0] : cnt_m3[ADDR_W:1];
		w_wdata = (state_q == S_CLEAR) ? 32'd0 : w_new;
		w_raddr = ofs_idx;
	end

	fxnlms_ram #(.WIDTH(16), .DEPTH(ADAPT_TAPS)) u_ref_ram (
		.clk(clk), .we(ref_we), .waddr(ref_waddr), .wdata(ref_wdata),
		.raddr(ref_raddr), .rdata(ref_rd)
	);

	fxnlms_ram #(.WIDTH(24), .DEPTH(ADAPT_TAPS)) u_fref_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rd)
	);

	fxnlms_ram #(.WIDTH(32), .DEPTH(ADAPT_TAPS)) u_weight_ram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rd)
	);

	// multiplier pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			ram_s1 <= 1'b0;
			neg_s1 <= 1'b0;
			neg_s2 <= 1'b0;
		end else begin
			v_s1   <= issue;
			ram_s1 <= issue && (state_q == S_Y);
			neg_s1 <= issue && (state_q == S_POW) && (cnt_q == '0);
			v_s2   <= v_s1;
			neg_s2 <= neg_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul_a * mul_b;
		unique case (state_q)
			S_PRI: begin
				opa_s1 <= {{(MA_W-16){pri_c[15]}}, pri_c};
				opb_s1 <= {{(MB_W-16){recent_q[cnt_q[REC_IW-1:0]][15]}},
				           recent_q[cnt_q[REC_IW-1:0]]};
			end
			S_SEC: begin
				opa_s1 <= {ah_q[cnt_q[SEC_IW-1:0]][31], ah_q[cnt_q[SEC_IW-1:0]]};
				opb_s1 <= {{(MB_W-16){sec_c[15]}}, sec_c};
			end
			S_XF: begin
				// reference taps past the history length read as zero
				opa_s1 <= {{(MA_W-16){sec_c[15]}}, sec_c};
				opb_s1 <= (cnt_q < CNT_W'(ADAPT_TAPS))
				        ? {{(MB_W-16){recent_q[cnt_q[REC_IW-1:0]][15]}},
				           recent_q[cnt_q[REC_IW-1:0]]}
				        : '0;
			end
			S_POW: begin
				if (cnt_q == '0) begin
					opa_s1 <= {{(MA_W-24){oldf_q[23]}}, oldf_q};
					opb_s1 <= {oldf_q[23], oldf_q};
				end else begin
					opa_s1 <= {{(MA_W-24){f_q[23]}}, f_q};
					opb_s1 <= {f_q[23], f_q};
				end
			end
			S_EMAG: begin
				opa_s1 <= {{(MA_W-17){1'b0}}, e_abs};
				opb_s1 <= {{(MB_W-16){1'b0}}, step_q};
			end
			default: begin
				opa_s1 <= '0;
				opb_s1 <= '0;
			end
		endcase

		// update pipeline: capture operands on odd steps, low product on even steps
		if (state_q == S_UPD) begin
			if (cnt_q[0]) begin
				xi_q <= f_rd;
				w_q  <= w_rd;
			end else begin
				lo_q <= prod_s2[LO_W-1:0];
			end
		end
	end

	// apb register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= STEP_RESET;
		else if (cfg_wr) step_q <= pwdata[15:0];
	end

	// sequencer and datapath state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			head_q      <= '0;
			pow_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < REC_TAPS; i++) recent_q[i] <= '0;
			for (int i = 0; i < SECONDARY_TAPS; i++) ah_q[i] <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_DONE)) out_valid_q <= 1'b0;

			if (v_s2) begin
				if (neg_s2) acc_q <= acc_q - {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
				else        acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
			end

			if (mac_state) begin
				if (mac_last) cnt_q <= '0;
				else          cnt_q <= cnt_q + CNT_W'(1);
			end

			unique case (state_q)
				S_CLEAR: begin
					// memory clearing sweep
					if (cnt_q == CNT_W'(ADAPT_TAPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						head_q      <= head_dec;
						recent_q[0] <= reference_sample;
						for (int i = 1; i < REC_TAPS; i++) recent_q[i] <= recent_q[i-1];
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_PRI;
					end
				end
				S_PRI: begin
					// oldest filtered reference, read at accept
					if (cnt_q == '0) oldf_q <= f_rd;
					if (mac_last) state_q <= S_Y;
				end
				S_Y: begin
					if (cnt_q == '0) begin
						d_q   <= acc_q[D_W-1:0];
						acc_q <= '0;
					end
					if (mac_last) state_q <= S_YFIN;
				end
				S_YFIN: begin
					ah_q[0] <= an_new;
					for (int i = 1; i < SECONDARY_TAPS; i++) ah_q[i] <= ah_q[i-1];
					acc_q   <= '0;
					state_q <= S_SEC;
				end
				S_SEC: begin
					if (mac_last) state_q <= S_XF;
				end
				S_XF: begin
					if (cnt_q == '0) begin
						y1_q  <= acc_q[Y1_W-1:0];
						acc_q <= '0;
					end
					if (mac_last) state_q <= S_XFIN;
				end
				S_XFIN: begin
					f_q     <= f_new;
					acc_q   <= ACC_W'(pow_q);
					state_q <= S_POW;
				end
				S_POW: begin
					if (mac_last) state_q <= S_ERR;
				end
				S_ERR: begin
					pow_q   <= acc_q;
					e_q     <= e_new;
					acc_q   <= '0;
					state_q <= S_EMAG;
				end
				S_EMAG: begin
					if (mac_last) state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring division, one quotient bit a cycle
					if (cnt_q == '0) begin
						num_q <= {acc_q[EMAG_W-1:0], 24'd0};
						rem_q <= '0;
						dvs_q <= pow_q + DVS_W'(4096);
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						rem_q <= rem_ge ? (rem_sh - dvs_q) : rem_sh;
						num_q <= {num_q[K_W-2:0], rem_ge};
						if (cnt_q == CNT_W'(K_W)) begin
							cnt_q   <= '0;
							state_q <= S_UPD;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_UPD: begin
					if (cnt_q == UPD_LAST) begin
						cnt_q   <= '0;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_data_q  <= e_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// an accepted request always starts the primary path
	a_accept_to_pri: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_PRI))
		else $error("accepted request did not start the primary path");

	// finishing a request always presents a result
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !(out_valid_q && out_stall)) |=> out_valid_q)
		else $error("finished request did not produce a result");

	// mac pipeline is drained while the update owns the multiplier
	a_upd_no_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> (!v_s1 && !v_s2))
		else $error("mac pipeline busy during weight update");

	// divisor never zero while dividing
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q != '0) |-> (dvs_q != '0))
		else $error("zero divisor");

	// history pointer stays inside the memory
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < ADDR_W'(ADAPT_TAPS - 1) || head_q == ADDR_W'(ADAPT_TAPS - 1))
		else $error("history pointer out of range");
`endif

endmodule
